>>> rtl/slp_pkg.sv
`timescale 1ns / 1ps

package slp_pkg;

  // Address path width (all address sums wrap at this width)
  localparam int ADDR_W = 32;

  // Token queue between the character front end and the record engine
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Result kinds carried on out_tuser
  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } out_kind_t;

  // Result status codes
  localparam logic [2:0] ST_OK   = 3'd0;
  localparam logic [2:0] ST_CSUM = 3'd1;
  localparam logic [2:0] ST_OOM  = 3'd6;

  // One classified character
  typedef struct packed {
    logic       line_err;   // line status 1..4
    logic [2:0] err_status; // status code for a line error
    logic       is_s;       // character is 'S'
    logic       rec_ok;     // character is a supported record type
    logic [2:0] rec_kind;   // [1:0] address bytes - 2, [2] end record
    logic [3:0] nib;        // hex value, 0 for non-hex
  } tok_t;

endpackage

>>> rtl/srecord_stream_loader_unit.sv
`timescale 1ns / 1ps
// S-record stream loader.
// Input stream: one received character per transaction, in_tdata[7:0] the
// character, in_tdata[10:8] its line status. Output stream: at most one result
// per character, out_tuser the result kind (memory write, done, error halt),
// out_tdata the address, data byte and status.
// Configuration: cfg_wr_en with cfg_index 0 (window base) or 1 (window length)
// and cfg_wdata; write only while the block is idle.
// A character is written into the token queue on the edge that accepts it; the
// engine pops it once the result register is free or being taken, and registers its result.
// Throughput: one character per cycle while the output is not stalled, set by the
// record engine reading the four-entry token queue.
// A stalled output holds its result; the queue keeps accepting until it holds
// four characters, then in_tready drops.
// Reset (synchronous, rst_n low) clears the queue, the window registers and
// the engine, which then hunts for the next 'S'. After a done or an error
// result, all characters are consumed and dropped until the next reset.
module srecord_stream_loader_unit
  import slp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // character input
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // rx_char[7:0], line_status[10:8], zero pad
  // results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // mem_address[31:0], write_byte[39:32],
                                  // status[42:40], zero pad
  output logic [1:0]  out_tuser,  // out_kind[1:0]
  // configuration
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  tok_t              in_tok, q_tok;
  logic              q_full, q_valid, q_pop;
  out_kind_t         res_kind;
  logic [ADDR_W-1:0] res_addr;
  logic [7:0]        res_byte;
  logic [2:0]        res_status;

  // character classification
  slp_front u_front (
    .rx_char     (in_tdata[7:0]),
    .line_status (in_tdata[10:8]),
    .tok         (in_tok)
  );

  assign in_tready = !q_full;

  // token queue
  slp_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_tvalid && !q_full),
    .push_tok (in_tok),
    .full     (q_full),
    .pop      (q_pop),
    .pop_tok  (q_tok),
    .valid    (q_valid)
  );

  // record engine
  slp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .tok_valid  (q_valid),
    .tok        (q_tok),
    .tok_pop    (q_pop),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res_kind   (res_kind),
    .res_addr   (res_addr),
    .res_byte   (res_byte),
    .res_status (res_status)
  );

  assign out_tuser = res_kind;
  assign out_tdata = {5'd0, res_status, res_byte, res_addr};

endmodule

>>> rtl/slp_front.sv
`timescale 1ns / 1ps

module slp_front
  import slp_pkg::*;
(
  input  logic [7:0] rx_char,
  input  logic [2:0] line_status,
  output tok_t       tok
);

  localparam logic [7:0] CH_S = 8'h53;
  localparam logic [7:0] CH_1 = 8'h31;
  localparam logic [7:0] CH_2 = 8'h32;
  localparam logic [7:0] CH_3 = 8'h33;
  localparam logic [7:0] CH_7 = 8'h37;
  localparam logic [7:0] CH_8 = 8'h38;
  localparam logic [7:0] CH_9 = 8'h39;
  localparam logic [7:0] CH_0 = 8'h30;
  localparam logic [7:0] CH_UA = 8'h41;
  localparam logic [7:0] CH_UF = 8'h46;
  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_LF = 8'h66;

  logic is_digit;
  logic is_alpha;

  // hex classification: letters of either case map to low bits + 9
  assign is_digit = (rx_char >= CH_0) && (rx_char <= CH_9);
  assign is_alpha = ((rx_char >= CH_UA) && (rx_char <= CH_UF)) ||
                    ((rx_char >= CH_LA) && (rx_char <= CH_LF));

  always_comb begin
    tok            = '0;
    tok.line_err   = (line_status != 3'd0) && (line_status <= 3'd4);
    tok.err_status = line_status + 3'd1;
    tok.is_s       = (rx_char == CH_S);
    if (is_digit) begin
      tok.nib = rx_char[3:0];
    end else if (is_alpha) begin
      tok.nib = rx_char[3:0] + 4'd9;
    end

    // record type decode
    tok.rec_ok = 1'b1;
    unique case (rx_char)
      CH_1:    tok.rec_kind = 3'd0;
      CH_2:    tok.rec_kind = 3'd1;
      CH_3:    tok.rec_kind = 3'd2;
      CH_9:    tok.rec_kind = 3'd4;
      CH_8:    tok.rec_kind = 3'd5;
      CH_7:    tok.rec_kind = 3'd6;
      default: begin
        tok.rec_kind = 3'd0;
        tok.rec_ok   = 1'b0;
      end
    endcase
  end

endmodule

>>> rtl/slp_fifo.sv
`timescale 1ns / 1ps

module slp_fifo
  import slp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  tok_t push_tok,
  output logic full,
  input  logic pop,
  output tok_t pop_tok,
  output logic valid
);

  tok_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r;
  logic [FIFO_AW-1:0] rd_ptr_r;
  logic [FIFO_AW:0]   cnt_r;

  assign full    = (cnt_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign valid   = (cnt_r != '0);
  assign pop_tok = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_tok;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

>>> rtl/slp_back.sv
`timescale 1ns / 1ps

module slp_back
  import slp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // configuration
  input  logic              cfg_wr_en,
  input  logic [1:0]        cfg_index,
  input  logic [ADDR_W-1:0] cfg_wdata,
  // token queue
  input  logic              tok_valid,
  input  tok_t              tok,
  output logic              tok_pop,
  // results
  output logic              res_valid,
  input  logic              res_ready,
  output out_kind_t         res_kind,
  output logic [ADDR_W-1:0] res_addr,
  output logic [7:0]        res_byte,
  output logic [2:0]        res_status
);

  typedef enum logic [7:0] {
    PH_HUNT  = 8'b0000_0001,
    PH_TYPE  = 8'b0000_0010,
    PH_COUNT = 8'b0000_0100,
    PH_ADDR  = 8'b0000_1000,
    PH_DATA  = 8'b0001_0000,
    PH_CSUM  = 8'b0010_0000,
    PH_DONE  = 8'b0100_0000,
    PH_HALT  = 8'b1000_0000
  } phase_t;

  localparam logic [1:0] REG_BASE   = 2'd0;
  localparam logic [1:0] REG_LENGTH = 2'd1;

  // configuration; window end kept precomputed
  logic [ADDR_W-1:0] base_r, length_r, end_r;

  phase_t            phase_r, phase_nxt;
  logic [3:0]        hi_r, hi_nxt;
  logic              pend_r, pend_nxt;
  logic [2:0]        kind_r, kind_nxt;
  logic [7:0]        count_r, count_nxt;
  logic [2:0]        left_r, left_nxt;
  logic [ADDR_W-1:0] acc_r, acc_nxt;
  logic [7:0]        sum_r, sum_nxt;
  logic [ADDR_W-1:0] wptr_r, wptr_nxt;

  logic              valid_r, valid_nxt;
  out_kind_t         rkind_r, rkind_nxt;
  logic [ADDR_W-1:0] raddr_r, raddr_nxt;
  logic [7:0]        rbyte_r, rbyte_nxt;
  logic [2:0]        rstat_r, rstat_nxt;

  logic [7:0]        cur_byte;
  logic [2:0]        wide;
  logic [ADDR_W-1:0] shifted, resolved;
  logic              in_win, oom;

  assign tok_pop    = tok_valid && (!valid_r || res_ready);
  assign res_valid  = valid_r;
  assign res_kind   = rkind_r;
  assign res_addr   = raddr_r;
  assign res_byte   = rbyte_r;
  assign res_status = rstat_r;

  // byte assembly and address window resolution
  assign cur_byte = {hi_r, tok.nib};
  assign wide     = {1'b0, kind_r[1:0]} + 3'd2;
  assign shifted  = {acc_r[ADDR_W-9:0], cur_byte};
  assign in_win   = (shifted >= base_r) && (shifted <= end_r);
  assign resolved = in_win ? shifted : (base_r + shifted);
  assign oom      = (resolved < base_r) || (resolved > end_r);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= '0;
      length_r <= '0;
      end_r    <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_BASE: begin
          base_r <= cfg_wdata;
          end_r  <= cfg_wdata + length_r;
        end
        REG_LENGTH: begin
          length_r <= cfg_wdata;
          end_r    <= base_r + cfg_wdata;
        end
        default: ;
      endcase
    end
  end

  // record engine
  always_comb begin
    phase_nxt = phase_r;
    hi_nxt    = hi_r;
    pend_nxt  = pend_r;
    kind_nxt  = kind_r;
    count_nxt = count_r;
    left_nxt  = left_r;
    acc_nxt   = acc_r;
    sum_nxt   = sum_r;
    wptr_nxt  = wptr_r;
    valid_nxt = valid_r && !res_ready;
    rkind_nxt = rkind_r;
    raddr_nxt = raddr_r;
    rbyte_nxt = rbyte_r;
    rstat_nxt = rstat_r;

    if (tok_pop) begin
      unique case (phase_r) inside
        PH_HUNT: begin
          if (!tok.line_err && tok.is_s) phase_nxt = PH_TYPE;
        end
        PH_TYPE: begin
          pend_nxt = 1'b0;
          if (tok.line_err || !tok.rec_ok) begin
            phase_nxt = PH_HUNT;
          end else begin
            kind_nxt  = tok.rec_kind;
            phase_nxt = PH_COUNT;
          end
        end
        PH_COUNT, PH_ADDR, PH_DATA, PH_CSUM: begin
          if (tok.line_err) begin
            phase_nxt = PH_HALT;
            valid_nxt = 1'b1;
            rkind_nxt = KIND_ERROR;
            raddr_nxt = '0;
            rbyte_nxt = '0;
            rstat_nxt = tok.err_status;
          end else if (!pend_r) begin
            hi_nxt   = tok.nib;
            pend_nxt = 1'b1;
          end else begin
            pend_nxt = 1'b0;
            unique case (phase_r)
              PH_COUNT: begin
                count_nxt = cur_byte;
                sum_nxt   = cur_byte;
                acc_nxt   = '0;
                left_nxt  = wide;
                phase_nxt = PH_ADDR;
              end
              PH_ADDR: begin
                acc_nxt  = shifted;
                sum_nxt  = sum_r + cur_byte;
                left_nxt = left_r - 3'd1;
                if (left_r == 3'd1) begin
                  if (oom) begin
                    phase_nxt = PH_HALT;
                    valid_nxt = 1'b1;
                    rkind_nxt = KIND_ERROR;
                    raddr_nxt = '0;
                    rbyte_nxt = '0;
                    rstat_nxt = ST_OOM;
                  end else begin
                    acc_nxt  = resolved;
                    wptr_nxt = resolved;
                    // data bytes = count - address bytes - checksum byte
                    if (count_r > {5'd0, wide}) begin
                      count_nxt = count_r - {5'd0, wide} - 8'd1;
                      phase_nxt = (count_r == {5'd0, wide} + 8'd1) ? PH_CSUM : PH_DATA;
                    end else begin
                      count_nxt = 8'd0;
                      phase_nxt = PH_CSUM;
                    end
                  end
                end
              end
              PH_DATA: begin
                sum_nxt   = sum_r + cur_byte;
                wptr_nxt  = wptr_r + 1'b1;
                count_nxt = count_r - 8'd1;
                if (count_r == 8'd1) phase_nxt = PH_CSUM;
                valid_nxt = 1'b1;
                rkind_nxt = KIND_WRITE;
                raddr_nxt = wptr_r;
                rbyte_nxt = cur_byte;
                rstat_nxt = ST_OK;
              end
              default: begin
                // checksum byte
                if (cur_byte != ~sum_r) begin
                  phase_nxt = PH_HALT;
                  valid_nxt = 1'b1;
                  rkind_nxt = KIND_ERROR;
                  raddr_nxt = '0;
                  rbyte_nxt = '0;
                  rstat_nxt = ST_CSUM;
                end else if (kind_r[2]) begin
                  phase_nxt = PH_DONE;
                  valid_nxt = 1'b1;
                  rkind_nxt = KIND_DONE;
                  raddr_nxt = acc_r;
                  rbyte_nxt = '0;
                  rstat_nxt = ST_OK;
                end else begin
                  phase_nxt = PH_HUNT;
                end
              end
            endcase
          end
        end
        default: ; // done or halted: characters are dropped
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      hi_r    <= '0;
      pend_r  <= 1'b0;
      kind_r  <= '0;
      count_r <= '0;
      left_r  <= '0;
      acc_r   <= '0;
      sum_r   <= '0;
      wptr_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      hi_r    <= hi_nxt;
      pend_r  <= pend_nxt;
      kind_r  <= kind_nxt;
      count_r <= count_nxt;
      left_r  <= left_nxt;
      acc_r   <= acc_nxt;
      sum_r   <= sum_nxt;
      wptr_r  <= wptr_nxt;
      valid_r <= valid_nxt;
    end
  end

  // result payload register
  always_ff @(posedge clk) begin
    rkind_r <= rkind_nxt;
    raddr_r <= raddr_nxt;
    rbyte_r <= rbyte_nxt;
    rstat_r <= rstat_nxt;
  end

endmodule

>>> rtl/slp_checker.sv
`timescale 1ns / 1ps

module slp_checker
  import slp_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic [1:0]  out_tuser
);

  logic finished_r;

  // set once a done or error result has been taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      finished_r <= 1'b0;
    end else if (out_tvalid && out_tready && (out_tuser != KIND_WRITE)) begin
      finished_r <= 1'b1;
    end
  end

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_quiet_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    finished_r |-> !out_tvalid)
    else $error("result after done or error");

  a_error_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_ERROR) |->
      (out_tdata[39:0] == 40'd0) && (out_tdata[42:40] != ST_OK))
    else $error("malformed error result");

  a_write_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_WRITE) |-> out_tdata[42:40] == ST_OK)
    else $error("write carries a status");

endmodule

bind srecord_stream_loader_unit slp_checker u_slp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
